[rtl/rlf_pkg.sv]
// ----------------------------------------------------------------------------
// rlf_pkg: shared types and constants of the running linear fit
// Widths of the running sums, the shared unit's word and the rounding helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlf_pkg;

    localparam int MAX_POINTS  = 131072;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 18;
    localparam int SUM_BITS    = 30;
    localparam int SQ_BITS     = 42;
    localparam int TOL_BITS    = 21;
    localparam int CFG_IDX_BITS = 2;

    // Word of the shared shift-add / restoring-divide unit.
    localparam int UW       = 160;
    localparam int STEP_BITS = 8;
    // Dividend bits walked by a division (numerator magnitude shifted by 16).
    localparam int DIV_BITS = 96;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_X      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIFF   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_R_TOL      = 2'd2;

    typedef struct packed {
        logic                 start;
        logic                 is_div;
        logic [STEP_BITS-1:0] steps;
    } rlf_op_t;

    // Round quotient to nearest (ties away from zero), apply sign, saturate.
    function automatic logic [31:0] rlf_round_sat(input logic [UW-1:0] q,
                                                  input logic [UW-1:0] rem,
                                                  input logic [UW-1:0] d,
                                                  input logic        neg);
        logic                  up;
        logic [DIV_BITS:0]     qr;
        logic [31:0]           res;
        up = ({rem, 1'b0} >= {1'b0, d});
        qr = {1'b0, q[DIV_BITS-1:0]} + (DIV_BITS+1)'(up);
        if (!neg)
        begin
            res = (qr > (DIV_BITS+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qr[31:0];
        end
        else
        begin
            res = (qr > (DIV_BITS+1)'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - qr[31:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/rlf_if.sv]
// ----------------------------------------------------------------------------
// rlf_if: stream channels of the running linear fit
// Sample pair channel and fit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rlf_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample_x;
    logic [11:0] sample_y;
    modport source (output valid, output sample_x, output sample_y, input ready);
    modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface rlf_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        converged;
    logic [17:0] point_count;
    logic [31:0] slope;
    logic [31:0] intercept;
    modport source (output valid, output accepted, output converged, output point_count,
                    output slope, output intercept, input ready);
    modport sink   (input valid, input accepted, input converged, input point_count,
                    input slope, input intercept, output ready);
endinterface

`default_nettype wire

[rtl/rlf_shared_unit.sv]
// ----------------------------------------------------------------------------
// rlf_shared_unit: bit-serial multiplier and restoring divider
// One adder serves both: one multiplier or dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlf_shared_unit
    import rlf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rlf_op_t       op,
    input  wire logic [UW-1:0] a,
    input  wire logic [UW-1:0] b,
    output logic               done,
    output logic [UW-1:0]      product,
    output logic [UW-1:0]      quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 div_reg;
    logic [STEP_BITS-1:0] idx_reg;
    logic [UW-1:0]        a_reg;
    logic [UW-1:0]        b_reg;
    logic [UW-1:0]        acc_reg;
    logic [UW-1:0]        q_reg;

    logic                 bit_sel;
    logic [UW-1:0]        shifted;
    logic [UW-1:0]        addend;
    logic [UW:0]          sum;
    logic [UW-1:0]        acc_next;

    always_comb
    begin
        bit_sel  = div_reg ? a_reg[idx_reg] : b_reg[idx_reg];
        shifted  = {acc_reg[UW-2:0], div_reg & bit_sel};
        addend   = div_reg ? ~b_reg : (bit_sel ? a_reg : '0);
        sum      = {1'b0, shifted} + {1'b0, addend} + (UW+1)'(div_reg);
        // For division the carry out says the partial remainder covers the divisor.
        acc_next = (div_reg && !sum[UW]) ? shifted : sum[UW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (op.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && idx_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            div_reg <= op.is_div;
            idx_reg <= op.steps - 1'b1;
            acc_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            q_reg   <= {q_reg[UW-2:0], sum[UW]};
            idx_reg <= idx_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign product  = acc_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

[rtl/running_linear_fit.sv]
// ----------------------------------------------------------------------------
// running_linear_fit: online least-squares line fit over ADC sample pairs
// Gates pairs, keeps running sums, tests correlation and latches slope and
// intercept in Q15.16 when the fit has converged.
// ----------------------------------------------------------------------------
//  channel   | direction | beat contents
//  ----------+-----------+-----------------------------------------------------
//  samples   | in        | sample_x, sample_y (12-bit unsigned ADC values)
//  results   | out       | accepted, converged, point_count, slope, intercept
//  cfg_*     | in        | write enable, register index, 21-bit write data
//
//  A rejected pair skips the shared unit. An accepted pair walks a sequence of
//  bit-serial products through one shared unit that retires one bit per cycle,
//  then two 96-bit divisions when slope and intercept are recomputed.
//  samples.ready is high only while the sequencer is idle; a finished result
//  waits in the output register, so the next pair is taken while it stalls.
//  Reset clears the sums, count and latched fit and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module running_linear_fit
    import rlf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    rlf_in_if.sink                       samples,
    rlf_out_if.source                    results,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [TOL_BITS-1:0]     cfg_data
);

    // Sequencer steps: each multiply or divide step launches the shared unit
    // once and captures its result when the unit reports done.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_NSXY    = 5'd1;
    localparam logic [4:0] S_SXSY    = 5'd2;
    localparam logic [4:0] S_NSXX    = 5'd3;
    localparam logic [4:0] S_SXSX    = 5'd4;
    localparam logic [4:0] S_NSYY    = 5'd5;
    localparam logic [4:0] S_SYSY    = 5'd6;
    localparam logic [4:0] S_VV      = 5'd7;
    localparam logic [4:0] S_CC      = 5'd8;
    localparam logic [4:0] S_KK      = 5'd9;
    localparam logic [4:0] S_KVV     = 5'd10;
    localparam logic [4:0] S_DSLOPE  = 5'd11;
    localparam logic [4:0] S_RSLOPE  = 5'd12;
    localparam logic [4:0] S_SYSXX   = 5'd13;
    localparam logic [4:0] S_SXSXY   = 5'd14;
    localparam logic [4:0] S_DICPT   = 5'd15;
    localparam logic [4:0] S_RICPT   = 5'd16;
    localparam logic [4:0] S_FINISH  = 5'd17;

    // Configuration registers.
    logic [SAMPLE_BITS-1:0] min_x_reg;
    logic [SAMPLE_BITS-1:0] max_diff_reg;
    logic [TOL_BITS-1:0]    r_tol_reg;

    // Running state.
    logic [SUM_BITS-1:0]    sx_reg;
    logic [SQ_BITS-1:0]     sxx_reg;
    logic [SQ_BITS-1:0]     sxy_reg;
    logic [SUM_BITS-1:0]    sy_reg;
    logic [SQ_BITS-1:0]     syy_reg;
    logic [COUNT_BITS-1:0]  n_reg;
    logic [31:0]            slope_reg;
    logic [31:0]            icpt_reg;

    // Sequencer and intermediate values.
    logic [4:0]             state_reg;
    logic [4:0]             state_next;
    logic                   launched_reg;
    logic                   acc_reg;
    logic                   conv_reg;
    logic [UW-1:0]          t0_reg;
    logic [UW-1:0]          t1_reg;
    logic [71:0]            c_reg;
    logic                   cneg_reg;
    logic [63:0]            vx_reg;
    logic [63:0]            vy_reg;
    logic [127:0]           vv_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_acc_reg;
    logic                   out_conv_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic [31:0]            out_slope_reg;
    logic [31:0]            out_icpt_reg;

    // Shared unit hookup.
    rlf_op_t                op;
    logic [UW-1:0]          op_a;
    logic [UW-1:0]          op_b;
    logic                   unit_done;
    logic [UW-1:0]          unit_prod;
    logic [UW-1:0]          unit_quot;

    // Gate and tolerance terms.
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] diff;
    logic [2*SAMPLE_BITS-1:0] xx_prod;
    logic [2*SAMPLE_BITS-1:0] xy_prod;
    logic [2*SAMPLE_BITS-1:0] yy_prod;
    logic                   gate_ok;
    logic                   in_beat;
    logic signed [TOL_BITS:0] cm;
    logic [TOL_BITS-1:0]    cabs;
    logic [UW-1:0]          lhs;
    logic                   conv_test;
    logic                   step_done;
    logic                   out_free;
    logic [UW-1:0]          diff_t;
    logic                   t0_less;

    rlf_shared_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .a        (op_a),
        .b        (op_b),
        .done     (unit_done),
        .product  (unit_prod),
        .quotient (unit_quot)
    );

    assign x       = samples.sample_x;
    assign y       = samples.sample_y;
    assign diff    = (x > y) ? (x - y) : (y - x);
    assign xx_prod = x * x;
    assign xy_prod = x * y;
    assign yy_prod = y * y;
    assign gate_ok = (x > min_x_reg) && (diff < max_diff_reg)
                     && (n_reg < COUNT_BITS'(MAX_POINTS));
    assign samples.ready = (state_reg == S_IDLE);
    assign in_beat = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    // Distance of the tolerance bound from one; its square scales Vx*Vy.
    assign cm   = $signed({1'b0, 21'h10_0000}) - $signed({1'b0, r_tol_reg});
    assign cabs = cm[TOL_BITS] ? TOL_BITS'(-cm) : cm[TOL_BITS-1:0];
    assign lhs  = {t0_reg[UW-41:0], 40'd0};

    always_comb
    begin
        if (!cm[TOL_BITS] && cm != '0)
        begin
            conv_test = !cneg_reg && (lhs > unit_prod);
        end
        else if (cm == '0)
        begin
            conv_test = !cneg_reg && (c_reg != '0);
        end
        else
        begin
            conv_test = !cneg_reg || (lhs < unit_prod);
        end
    end

    // Difference of the first and second products of a step pair.
    assign t0_less = (t0_reg < unit_prod);
    assign diff_t  = t0_less ? (unit_prod - t0_reg) : (t0_reg - unit_prod);

    // Operand selection for the shared unit. Unit states launch once, then
    // wait for done.
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        op.is_div = 1'b0;
        op.steps = '0;
        case (state_reg)
            S_NSXY:
            begin
                op_a = UW'(sxy_reg); op_b = UW'(n_reg); op.steps = STEP_BITS'(COUNT_BITS);
            end
            S_SXSY:
            begin
                op_a = UW'(sy_reg); op_b = UW'(sx_reg); op.steps = STEP_BITS'(SUM_BITS);
            end
            S_NSXX:
            begin
                op_a = UW'(sxx_reg); op_b = UW'(n_reg); op.steps = STEP_BITS'(COUNT_BITS);
            end
            S_SXSX:
            begin
                op_a = UW'(sx_reg); op_b = UW'(sx_reg); op.steps = STEP_BITS'(SUM_BITS);
            end
            S_NSYY:
            begin
                op_a = UW'(syy_reg); op_b = UW'(n_reg); op.steps = STEP_BITS'(COUNT_BITS);
            end
            S_SYSY:
            begin
                op_a = UW'(sy_reg); op_b = UW'(sy_reg); op.steps = STEP_BITS'(SUM_BITS);
            end
            S_VV:
            begin
                op_a = UW'(vy_reg); op_b = UW'(vx_reg); op.steps = 8'd64;
            end
            S_CC:
            begin
                op_a = UW'(c_reg); op_b = UW'(c_reg); op.steps = 8'd64;
            end
            S_KK:
            begin
                op_a = UW'(cabs); op_b = UW'(cabs); op.steps = STEP_BITS'(TOL_BITS);
            end
            S_KVV:
            begin
                op_a = UW'(vv_reg); op_b = t1_reg; op.steps = 8'd42;
            end
            S_DSLOPE, S_DICPT:
            begin
                op_a = UW'({c_reg, 16'd0}); op_b = UW'(vx_reg);
                op.is_div = 1'b1; op.steps = STEP_BITS'(DIV_BITS);
            end
            S_SYSXX:
            begin
                op_a = UW'(sxx_reg); op_b = UW'(sy_reg); op.steps = STEP_BITS'(SUM_BITS);
            end
            S_SXSXY:
            begin
                op_a = UW'(sxy_reg); op_b = UW'(sx_reg); op.steps = STEP_BITS'(SUM_BITS);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
        case (state_reg)
            S_IDLE, S_RSLOPE, S_RICPT, S_FINISH: op.start = 1'b0;
            default:                             op.start = !launched_reg;
        endcase
    end
    assign step_done = launched_reg && unit_done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_beat) state_next = gate_ok ? S_NSXY : S_FINISH;
            S_NSXY:   if (step_done) state_next = S_SXSY;
            S_SXSY:   if (step_done) state_next = S_NSXX;
            S_NSXX:   if (step_done) state_next = S_SXSX;
            S_SXSX:   if (step_done) state_next = t0_less ? S_FINISH : S_NSYY;
            S_NSYY:   if (step_done) state_next = S_SYSY;
            S_SYSY:   if (step_done) state_next = t0_less ? S_FINISH : S_VV;
            S_VV:     if (step_done) state_next = (unit_prod == '0) ? S_FINISH : S_CC;
            S_CC:     if (step_done) state_next = S_KK;
            S_KK:     if (step_done) state_next = S_KVV;
            S_KVV:    if (step_done) state_next = conv_test ? S_DSLOPE : S_FINISH;
            S_DSLOPE: if (step_done) state_next = S_RSLOPE;
            S_RSLOPE: state_next = S_SYSXX;
            S_SYSXX:  if (step_done) state_next = S_SXSXY;
            S_SXSXY:  if (step_done) state_next = S_DICPT;
            S_DICPT:  if (step_done) state_next = S_RICPT;
            S_RICPT:  state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state, configuration, running sums and latched fit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            min_x_reg     <= 12'd1000;
            max_diff_reg  <= 12'd300;
            r_tol_reg     <= 21'd1049;
            sx_reg        <= '0;
            sxx_reg       <= '0;
            sxy_reg       <= '0;
            sy_reg        <= '0;
            syy_reg       <= '0;
            n_reg         <= '0;
            slope_reg     <= '0;
            icpt_reg      <= '0;
            acc_reg       <= 1'b0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (op.start)
            begin
                launched_reg <= 1'b1;
            end
            else if (step_done)
            begin
                launched_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_X:    min_x_reg    <= cfg_data[SAMPLE_BITS-1:0];
                    REG_MAX_DIFF: max_diff_reg <= cfg_data[SAMPLE_BITS-1:0];
                    REG_R_TOL:    r_tol_reg    <= cfg_data;
                    default:      ;
                endcase
            end

            if (in_beat)
            begin
                acc_reg  <= gate_ok;
                conv_reg <= 1'b0;
                if (gate_ok)
                begin
                    sx_reg  <= sx_reg + SUM_BITS'(x);
                    sxx_reg <= sxx_reg + SQ_BITS'(xx_prod);
                    sxy_reg <= sxy_reg + SQ_BITS'(xy_prod);
                    sy_reg  <= sy_reg + SUM_BITS'(y);
                    syy_reg <= syy_reg + SQ_BITS'(yy_prod);
                    n_reg   <= n_reg + 1'b1;
                end
            end

            if (state_reg == S_RSLOPE)
            begin
                slope_reg <= rlf_round_sat(unit_quot, unit_prod, UW'(vx_reg), cneg_reg);
            end
            if (state_reg == S_RICPT)
            begin
                icpt_reg <= rlf_round_sat(unit_quot, unit_prod, UW'(vx_reg), cneg_reg);
                conv_reg <= 1'b1;
            end

            if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Intermediate products and the output data fields carry no reset.
    always_ff @(posedge clk)
    begin
        if (step_done)
        begin
            case (state_reg)
                S_NSXY, S_NSXX, S_NSYY, S_CC, S_SYSXX: t0_reg <= unit_prod;
                S_SXSY, S_SXSXY:
                begin
                    c_reg    <= diff_t[71:0];
                    cneg_reg <= t0_less;
                end
                S_SXSX: vx_reg <= diff_t[63:0];
                S_SYSY: vy_reg <= diff_t[63:0];
                S_VV:   vv_reg <= unit_prod[127:0];
                S_KK:   t1_reg <= unit_prod;
                default: ;
            endcase
        end
        if (state_reg == S_FINISH && out_free)
        begin
            out_acc_reg   <= acc_reg;
            out_conv_reg  <= conv_reg;
            out_count_reg <= n_reg;
            out_slope_reg <= slope_reg;
            out_icpt_reg  <= icpt_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.accepted    = out_acc_reg;
    assign results.converged   = out_conv_reg;
    assign results.point_count = out_count_reg;
    assign results.slope       = out_slope_reg;
    assign results.intercept   = out_icpt_reg;

endmodule

`default_nettype wire

[rtl/rlf_checker.sv]
// ----------------------------------------------------------------------------
// rlf_checker: port-level checks of the running linear fit
// Watches the sample and result channels and binds to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlf_checker
    import rlf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  out_accepted,
    input wire logic                  out_converged,
    input wire logic [COUNT_BITS-1:0] out_count,
    input wire logic [31:0]           out_slope
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_slope))
        else $error("stalled slope changed");

    a_conv_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_converged || out_accepted)
        else $error("converged without accepted point");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while previous pair in work");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count <= COUNT_BITS'(MAX_POINTS))
        else $error("point count beyond limit");

endmodule

bind running_linear_fit rlf_checker u_rlf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_accepted  (results.accepted),
    .out_converged (results.converged),
    .out_count     (results.point_count),
    .out_slope     (results.slope)
);

`default_nettype wire
